FILE: src/hex_event_word_decoder_macros.svh
// Assertion macros used by hev_decode.
`ifndef HEX_EVENT_WORD_DECODER_MACROS_SVH
`define HEX_EVENT_WORD_DECODER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HEV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define HEV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hev_pkg.sv
`timescale 1ns / 1ps

package hev_pkg;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_WRAP  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_HALT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  x_pos;
    logic [6:0]  y_pos;
    logic        polarity;
    logic        channel_bit;
    logic [31:0] time_stamp;
  } result_t;

  localparam logic [7:0]  CHAR_EIGHT     = 8'h38;
  localparam logic [3:0]  DIGIT_EIGHT    = 4'd8;
  localparam logic [31:0] WRAP_STEP      = 32'h0100_0000;

  localparam logic [3:0]  POS_IDLE       = 4'd0;
  localparam logic [3:0]  POS_SECOND     = 4'd1;
  localparam logic [3:0]  POS_STAMP_LAST = 4'd7;
  localparam logic [3:0]  POS_SKIP_LAST  = 4'd11;
  localparam logic [3:0]  POS_ADDR_LAST  = 4'd14;

  function automatic logic is_space(input logic [7:0] c);
    logic sp;
    sp = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    return sp;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

FILE: src/hev_in_stage.sv
`timescale 1ns / 1ps

module hev_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       out_free_i,
  output logic       step_o,
  output logic [7:0] char_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       accept;

  assign in_stall_o = valid_q && !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign step_o     = valid_q && out_free_i;
  assign char_o     = char_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_code_i;
    end
  end

endmodule

FILE: src/hev_decode.sv
`timescale 1ns / 1ps
`include "hex_event_word_decoder_macros.svh"

module hev_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       char_i,
  input  logic [3:0]       allowance_i,
  output logic             res_valid_o,
  output hev_pkg::result_t res_o
);

  logic [3:0]  pos_q, pos_d;
  logic        wrap_q, wrap_d;
  logic [23:0] stamp_q, stamp_d;
  logic [11:0] addr_q, addr_d;
  logic [31:0] offset_q, offset_d;
  logic [3:0]  err_q, err_d;
  logic        halted_q, halted_d;
  logic [3:0]  d;
  logic [7:0]  y_byte;

  assign d      = hev_pkg::hex_value(char_i);
  assign y_byte = {addr_q[3:0], d};

  always_comb begin
    pos_d       = pos_q;
    wrap_d      = wrap_q;
    stamp_d     = stamp_q;
    addr_d      = addr_q;
    offset_d    = offset_q;
    err_d       = err_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i && !halted_q && !hev_pkg::is_space(char_i)) begin
      if (pos_q == hev_pkg::POS_IDLE) begin
        if (char_i == hev_pkg::CHAR_EIGHT) begin
          pos_d   = hev_pkg::POS_SECOND;
          wrap_d  = 1'b0;
          stamp_d = '0;
          addr_d  = '0;
        end else begin
          res_valid_o = 1'b1;
          if (err_q < allowance_i) begin
            err_d      = err_q + 4'd1;
            res_o.kind = hev_pkg::KIND_BAD;
          end else begin
            halted_d   = 1'b1;
            res_o.kind = hev_pkg::KIND_HALT;
          end
        end
      end else if (pos_q == hev_pkg::POS_SECOND) begin
        wrap_d = (d == hev_pkg::DIGIT_EIGHT);
        pos_d  = pos_q + 4'd1;
      end else if (wrap_q) begin
        if (pos_q >= hev_pkg::POS_STAMP_LAST) begin
          offset_d         = offset_q + hev_pkg::WRAP_STEP;
          pos_d            = hev_pkg::POS_IDLE;
          wrap_d           = 1'b0;
          res_valid_o      = 1'b1;
          res_o.kind       = hev_pkg::KIND_WRAP;
          res_o.time_stamp = offset_d;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end else if (pos_q <= hev_pkg::POS_STAMP_LAST) begin
        stamp_d = {stamp_q[19:0], d};
        pos_d   = pos_q + 4'd1;
      end else if (pos_q <= hev_pkg::POS_SKIP_LAST) begin
        pos_d = pos_q + 4'd1;
      end else if (pos_q <= hev_pkg::POS_ADDR_LAST) begin
        addr_d = {addr_q[7:0], d};
        pos_d  = pos_q + 4'd1;
      end else begin
        res_valid_o       = 1'b1;
        res_o.kind        = hev_pkg::KIND_EVENT;
        res_o.x_pos       = {addr_q[10:8], addr_q[7:4]};
        res_o.y_pos       = y_byte[7:1];
        res_o.polarity    = addr_q[8];
        res_o.channel_bit = d[3];
        res_o.time_stamp  = offset_q + {8'h00, stamp_q};
        pos_d             = hev_pkg::POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= hev_pkg::POS_IDLE;
      wrap_q   <= 1'b0;
      stamp_q  <= '0;
      addr_q   <= '0;
      offset_q <= '0;
      err_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      wrap_q   <= wrap_d;
      stamp_q  <= stamp_d;
      addr_q   <= addr_d;
      offset_q <= offset_d;
      err_q    <= err_d;
      halted_q <= halted_d;
    end
  end

  `HEV_ASSERT(a_wrap_pos_bound, clk_i, rst_ni, !wrap_q || (pos_q <= hev_pkg::POS_STAMP_LAST), "wrap word position out of range")
  `HEV_ASSERT(a_quiet_when_halted, clk_i, rst_ni, !(halted_q && res_valid_o), "result while halted")
  `HEV_ASSERT_NEXT(a_halt_sticks, clk_i, rst_ni, halted_q || (res_valid_o && (res_o.kind == hev_pkg::KIND_HALT)), halted_q, "halt not held")

endmodule

FILE: src/hev_out_stage.sv
`timescale 1ns / 1ps

module hev_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hev_pkg::result_t res_i,
  output logic             out_free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hev_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  hev_pkg::result_t res_q;

  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: src/hex_event_word_decoder.sv
`timescale 1ns / 1ps
// Decodes a hex text dump of address events one character per beat and accepts a new
// character every cycle unless the input is stalled. Each accepted character is held in
// the input register, and its result is loaded into the result register, which drives
// the outputs. The input stalls only while both registers hold a beat and the
// output is stalled. Whitespace is skipped, a word starting with a second 8 advances the
// time offset by 2^24, other words yield an event on their sixteenth character, and bad
// word starts are reported until the allowance in cfg_wdata_i runs out, after which the
// block reports a halt once and then stays silent until reset.
module hex_event_word_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [6:0]  x_pos_o,
  output logic [6:0]  y_pos_o,
  output logic        polarity_o,
  output logic        channel_bit_o,
  output logic [31:0] time_stamp_o
);

  logic [3:0]       allowance_val_q;
  logic             out_free;
  logic             step;
  logic [7:0]       char_s;
  logic             res_valid;
  hev_pkg::result_t res_s;
  hev_pkg::result_t res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowance_val_q <= 4'd1;
    end else if (cfg_we_i) begin
      allowance_val_q <= cfg_wdata_i;
    end
  end

  hev_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .out_free_i  (out_free),
    .step_o      (step),
    .char_o      (char_s)
  );

  hev_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_i      (char_s),
    .allowance_i (allowance_val_q),
    .res_valid_o (res_valid),
    .res_o       (res_s)
  );

  hev_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_s),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o        = res_out.kind;
  assign x_pos_o       = res_out.x_pos;
  assign y_pos_o       = res_out.y_pos;
  assign polarity_o    = res_out.polarity;
  assign channel_bit_o = res_out.channel_bit;
  assign time_stamp_o  = res_out.time_stamp;

endmodule
